/* rtl/core/srm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package srm_pkg;

  // Widths of the fixed-point samples and timestamps.
  localparam int VAL_W  = 32;
  localparam int TIME_W = 32;
  localparam int MARK_W = 34;
  localparam int PCT_W  = 31;

  // Divider numerator width: a 33-bit excess times the 100% scale factor.
  localparam int DIV_NW = 56;
  localparam int DIV_DW = 32;

  // 100.0 in Q16.16, and 1.0 in Q16.16 as the zero-setpoint bound (a band of 0.02).
  localparam logic [22:0] PCT_SCALE = 23'd6553600;
  localparam logic [31:0] BAND_ZERO = 32'd65536;
  localparam logic [30:0] MAX31     = 31'h7FFF_FFFF;

  typedef struct packed {
    logic load_in;
    logic init_run;
    logic div_start;
    logic store_pct;
    logic update;
    logic mul;
    logic emit;
  } srm_cmd_t;

  typedef struct packed {
    logic run_started;
    logic last;
    logic need_pct;
    logic div_done;
    logic out_busy;
  } srm_stat_t;

endpackage
`default_nettype wire

/* rtl/core/srm_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module srm_div
  import srm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] numer,
  input  wire logic [DIV_DW-1:0] denom,
  output logic      [DIV_NW-1:0] quot,
  output logic                   done
);

  localparam int CW = $clog2(DIV_NW);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DIV_NW-1:0] num_sh;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] den;
  logic [DIV_DW:0]   trial;
  logic              qbit;

  // One restoring step per cycle; quotient bits shift in behind the numerator.
  assign trial = {rem, num_sh[DIV_NW-1]};
  assign qbit  = (trial >= {1'b0, den});
  assign quot  = num_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_NW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= numer;
      rem    <= '0;
      den    <= denom;
    end else if (busy) begin
      num_sh <= {num_sh[DIV_NW-2:0], qbit};
      rem    <= qbit ? DIV_DW'(trial - {1'b0, den}) : trial[DIV_DW-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/srm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module srm_ctrl
  import srm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire srm_stat_t stat,
  output srm_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INIT     = 3'd1;
  localparam logic [2:0] S_UPDATE   = 3'd2;
  localparam logic [2:0] S_MUL      = 3'd3;
  localparam logic [2:0] S_DIV_PCT  = 3'd4;
  localparam logic [2:0] S_WAIT_PCT = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands for the datapath.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = stat.run_started ? S_UPDATE : S_INIT;
        end
      end
      S_INIT: begin
        cmd.init_run = 1'b1;
        state_next   = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = stat.last ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = stat.need_pct ? S_DIV_PCT : S_EMIT;
      end
      S_DIV_PCT: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT_PCT;
      end
      S_WAIT_PCT: begin
        if (stat.div_done) begin
          cmd.store_pct = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/srm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module srm_datapath
  import srm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     setpoint_wr,
  input  wire logic signed [VAL_W-1:0]  setpoint_data,
  input  wire logic signed [VAL_W-1:0]  sample_value,
  input  wire logic [TIME_W-1:0]        sample_time,
  input  wire logic                     last_sample,
  input  wire srm_cmd_t                 cmd,
  output srm_stat_t                     stat,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [TIME_W-1:0]             rise_duration,
  output logic                          rise_found,
  output logic [TIME_W-1:0]             settle_stamp,
  output logic [PCT_W-1:0]              overshoot_percent,
  output logic [PCT_W-1:0]              final_error,
  output logic signed [VAL_W-1:0]       peak_level
);

  logic signed [VAL_W-1:0]  setpoint;
  logic signed [VAL_W-1:0]  pv;
  logic signed [VAL_W-1:0]  sp;
  logic [TIME_W-1:0]        t;
  logic                     last;
  logic                     run_started;
  logic signed [VAL_W-1:0]  initial_value;
  logic                     rising_direction;
  logic [VAL_W:0]           step_mag;
  logic                     low_crossed;
  logic [TIME_W-1:0]        low_cross_time;
  logic                     rise_done;
  logic [TIME_W-1:0]        rise_ticks;
  logic signed [VAL_W-1:0]  running_peak;
  logic signed [VAL_W-1:0]  running_trough;
  logic                     outside_seen;
  logic [TIME_W-1:0]        last_outside_time;
  logic signed [MARK_W-1:0] excess;
  logic                     need_pct;
  logic [DIV_NW-1:0]        product;
  logic [PCT_W-1:0]         pct;

  logic signed [VAL_W:0]    diff;
  logic [VAL_W:0]           diff_mag;
  logic [VAL_W-1:0]         sp_mag;
  logic [DIV_NW-1:0]        div_quot;
  logic                     div_done;
  logic signed [VAL_W+1:0]  rise_off;
  logic signed [VAL_W+5:0]  rise_off10;
  logic signed [VAL_W+5:0]  lo_need;
  logic signed [VAL_W+5:0]  hi_need;
  logic signed [VAL_W-1:0]  peak_next;
  logic signed [VAL_W-1:0]  trough_next;
  logic                     cross_lo;
  logic                     cross_hi;
  logic [VAL_W+6:0]         err50;
  logic [VAL_W+6:0]         bound;
  logic signed [MARK_W-1:0] excess_next;
  logic [PCT_W-1:0]         pct_sat;

  // Error terms of the held sample against the held setpoint.
  assign diff     = (VAL_W+1)'(sp) - (VAL_W+1)'(pv);
  assign diff_mag = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;
  assign sp_mag   = sp[VAL_W-1] ? VAL_W'(-sp) : sp;

  // The divider only scales the overshoot by |setpoint|.
  srm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (product),
    .denom (sp_mag),
    .quot  (div_quot),
    .done  (div_done)
  );

  // Rise marks: ten times the progress from the initial value in the step
  // direction is compared against one and nine times the step size.
  assign rise_off   = rising_direction ? (VAL_W+2)'(pv) - (VAL_W+2)'(initial_value)
                                       : (VAL_W+2)'(initial_value) - (VAL_W+2)'(pv);
  assign rise_off10 = ((VAL_W+6)'(rise_off) << 3) + ((VAL_W+6)'(rise_off) << 1);
  assign lo_need    = (VAL_W+6)'(step_mag);
  assign hi_need    = ((VAL_W+6)'(step_mag) << 3) + (VAL_W+6)'(step_mag);
  assign cross_lo   = (rise_off10 >= lo_need);
  assign cross_hi   = (rise_off10 >= hi_need);

  assign peak_next   = (pv > running_peak) ? pv : running_peak;
  assign trough_next = (pv < running_trough) ? pv : running_trough;

  // Band test: 50 * |error| against |setpoint|, or 1.0 (a band of 0.02) for a zero setpoint.
  assign err50 = ((VAL_W+7)'(diff_mag) << 5) + ((VAL_W+7)'(diff_mag) << 4)
               + ((VAL_W+7)'(diff_mag) << 1);
  assign bound = (sp == '0) ? (VAL_W+7)'(BAND_ZERO) : (VAL_W+7)'(sp_mag);

  always_comb begin
    excess_next = '0;
    if (sp > initial_value) begin
      excess_next = MARK_W'(peak_next) - MARK_W'(sp);
    end else if (sp < initial_value) begin
      excess_next = MARK_W'(sp) - MARK_W'(trough_next);
    end
  end

  assign pct_sat = (div_quot > DIV_NW'(MAX31)) ? MAX31 : div_quot[PCT_W-1:0];

  assign stat.run_started = run_started;
  assign stat.last        = last;
  assign stat.need_pct    = need_pct;
  assign stat.div_done    = div_done;
  assign stat.out_busy    = out_valid && !out_ready;

  // Control flags and the result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint    <= '0;
      run_started <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (setpoint_wr) begin
        setpoint <= setpoint_data;
      end
      if (cmd.init_run) begin
        run_started <= 1'b1;
      end else if (cmd.emit) begin
        run_started <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Run state, updated one sample at a time.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pv   <= sample_value;
      t    <= sample_time;
      last <= last_sample;
      sp   <= setpoint;
    end
    if (cmd.init_run) begin
      initial_value     <= pv;
      rising_direction  <= !diff[VAL_W];
      step_mag          <= diff_mag;
      low_crossed       <= 1'b0;
      low_cross_time    <= '0;
      rise_done         <= 1'b0;
      rise_ticks        <= '0;
      running_peak      <= pv;
      running_trough    <= pv;
      outside_seen      <= 1'b0;
      last_outside_time <= '0;
    end
    if (cmd.update) begin
      running_peak   <= peak_next;
      running_trough <= trough_next;
      if (!low_crossed && cross_lo) begin
        low_crossed    <= 1'b1;
        low_cross_time <= t;
      end
      // The high mark is checked against the crossing state seen this sample.
      if ((low_crossed || cross_lo) && !rise_done && cross_hi) begin
        rise_done  <= 1'b1;
        rise_ticks <= t - (low_crossed ? low_cross_time : t);
      end
      if (err50 > bound) begin
        outside_seen      <= 1'b1;
        last_outside_time <= t;
      end
      excess   <= excess_next;
      need_pct <= (sp != '0) && (excess_next > 0);
    end
    if (cmd.mul) begin
      product <= DIV_NW'(excess[VAL_W:0]) * DIV_NW'(PCT_SCALE);
    end
    if (cmd.store_pct) begin
      pct <= pct_sat;
    end
    if (cmd.emit) begin
      rise_duration     <= rise_done ? rise_ticks : '0;
      rise_found        <= rise_done;
      settle_stamp      <= outside_seen ? last_outside_time : '0;
      overshoot_percent <= need_pct ? pct : '0;
      final_error       <= (diff_mag > (VAL_W+1)'(MAX31)) ? MAX31 : diff_mag[PCT_W-1:0];
      peak_level        <= running_peak;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/step_response_metrics.sv */
`timescale 1ns / 1ps
`default_nettype none
// Step-response metrics over a stream of timestamped Q16.16 samples.
// Input word (s_tdata): sample value, timestamp; s_tlast marks the final
// sample of a run. The target is written through setpoint_wr/setpoint_data
// while the block is idle, by the user; the block does not enforce it.
// One word is taken at a time. A sample that opens a run goes through capture,
// run setup and update, with s_tready low after it is taken; any later sample
// goes through capture and update. The 10% and 90% marks are tested by
// comparing ten times the progress against one and nine times the step.
// A final sample then goes through the multiply and emit states when there
// is no overshoot to scale, else a divider start and the 56-step radix-2
// divider lie between them. The result word is loaded once the output is free.
// Result word (m_tdata) goes to an output register; m_tuser is rise_found.
// A stalled receiver holds the result; the block still takes the next run's
// samples and waits only when a new result is ready to be loaded.
// Reset clears the setpoint, ends any open run and drops m_tvalid.
module step_response_metrics
  import srm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         setpoint_wr,
  input  wire logic [31:0]  setpoint_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // sample value [31:0], sample_time [63:32]
  input  wire logic [63:0]  s_tdata,
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // rise_duration [31:0], settle stamp [63:32], overshoot_percent [94:64],
  // final_error [125:95], peak level [157:126], zero fill [159:158]
  output logic [159:0]      m_tdata,
  // rise_found [0]
  output logic [0:0]        m_tuser
);

  srm_cmd_t                cmd;
  srm_stat_t               stat;
  logic [TIME_W-1:0]       rise_duration;
  logic                    rise_found;
  logic [TIME_W-1:0]       settle_stamp;
  logic [PCT_W-1:0]        overshoot_percent;
  logic [PCT_W-1:0]        final_error;
  logic signed [VAL_W-1:0] peak_level;

  srm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srm_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .setpoint_wr       (setpoint_wr),
    .setpoint_data     (setpoint_data),
    .sample_value      (s_tdata[31:0]),
    .sample_time       (s_tdata[63:32]),
    .last_sample       (s_tlast),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .rise_duration     (rise_duration),
    .rise_found        (rise_found),
    .settle_stamp      (settle_stamp),
    .overshoot_percent (overshoot_percent),
    .final_error       (final_error),
    .peak_level        (peak_level)
  );

  assign m_tdata = {2'b00, peak_level, final_error, overshoot_percent,
                    settle_stamp, rise_duration};
  assign m_tuser = rise_found;

endmodule
`default_nettype wire

/* rtl/core/srm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module srm_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         s_tlast,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [159:0] m_tdata,
  input wire logic [0:0]   m_tuser
);

  // A held result word does not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Each word is worked on alone, so no word is taken on the next edge.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive edges");

  // A sample that does not end a run never brings up a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && s_tvalid && s_tready && !s_tlast |=> !m_tvalid)
    else $error("result without a final sample");

  // Without a completed rise the rise duration reads zero.
  a_rise_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'd0)
    else $error("rise duration set without rise");

endmodule

bind step_response_metrics srm_checker u_srm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import srm_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] stamp;
    logic        last;
    logic        wr_sp;
    logic [31:0] sp;
  } sample_t;

  typedef struct packed {
    logic [31:0] rise_duration;
    logic        rise_found;
    logic [31:0] settle_stamp;
    logic [30:0] overshoot_percent;
    logic [30:0] final_error;
    logic [31:0] peak_level;
  } metrics_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic setpoint_wr = 1'b0;
  logic [31:0] setpoint_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic [0:0] m_tuser;

  sample_t pending_samples[$];
  metrics_t expected_metrics[$];
  int errors = 0;
  int cycle_count = 0;
  bit quiet_mode = 1'b0;
  int hold_cycles = 0;
  bit pause_req = 1'b0;

  // Predictor state.
  longint sp_q;
  bit started;
  longint init_v, lo_mark, hi_mark, peak_v, trough_v;
  bit rising, lo_seen, rise_seen, out_seen;
  logic [31:0] lo_time, rise_t, out_time;

  step_response_metrics uut (
    .clk(clk), .rst(rst), .setpoint_wr(setpoint_wr), .setpoint_data(setpoint_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint place_mark(longint base, longint d, longint num);
    longint q;
    q = (abs64(d) * num + 9) / 10;
    return d >= 0 ? base + q : base - q;
  endfunction

  function automatic bit crossed(longint v, longint mark);
    return rising ? (v >= mark) : (v <= mark);
  endfunction

  function automatic logic [30:0] clip31(longint v);
    return v > 64'sh7FFFFFFF ? 31'h7FFFFFFF : v[30:0];
  endfunction

  // Update the step metrics with one accepted sample.
  task automatic predict_metrics(logic [31:0] raw, logic [31:0] stamp, logic last);
    longint v, bound, excess;
    metrics_t m;
    v = longint'(signed'(raw));
    if (!started) begin
      started = 1'b1;
      init_v = v;
      rising = (sp_q - v) >= 0;
      lo_mark = place_mark(v, sp_q - v, 1);
      hi_mark = place_mark(v, sp_q - v, 9);
      lo_seen = 0; rise_seen = 0; out_seen = 0;
      lo_time = 0; rise_t = 0; out_time = 0;
      peak_v = v; trough_v = v;
    end
    if (v > peak_v) peak_v = v;
    if (v < trough_v) trough_v = v;
    if (!lo_seen && crossed(v, lo_mark)) begin
      lo_seen = 1; lo_time = stamp;
    end
    if (lo_seen && !rise_seen && crossed(v, hi_mark)) begin
      rise_seen = 1; rise_t = stamp - lo_time;
    end
    bound = (sp_q == 0) ? 65536 : abs64(sp_q);
    if (50 * abs64(sp_q - v) > bound) begin
      out_seen = 1; out_time = stamp;
    end
    if (last) begin
      m.overshoot_percent = '0;
      if (sp_q != 0) begin
        excess = 0;
        if (sp_q > init_v) excess = peak_v - sp_q;
        else if (sp_q < init_v) excess = sp_q - trough_v;
        if (excess > 0) m.overshoot_percent = clip31((excess * 6553600) / abs64(sp_q));
      end
      m.rise_duration = rise_seen ? rise_t : 32'd0;
      m.rise_found = rise_seen;
      m.settle_stamp = out_seen ? out_time : 32'd0;
      m.final_error = clip31(abs64(sp_q - v));
      m.peak_level = peak_v[31:0];
      expected_metrics.insert(expected_metrics.size(), m);
      started = 1'b0;
    end
  endtask

  // Sample driver; a setpoint change waits until the block has drained.
  // A pause takes effect only between runs.
  always @(posedge clk) begin
    if (!rst) begin
      setpoint_wr <= 1'b0;
      if (s_tvalid && s_tready) begin
        predict_metrics(s_tdata[31:0], s_tdata[63:32], s_tlast);
        void'(pending_samples.pop_front());
      end
      if (!(s_tvalid && !s_tready)) begin
        if (pending_samples.size() == 0 || (pause_req && !started)) begin
          s_tvalid <= 1'b0;
        end else if (pending_samples[0].wr_sp) begin
          s_tvalid <= 1'b0;
          if (expected_metrics.size() == 0 && !started && !(s_tvalid && s_tready)
              && !(m_tvalid)) begin
            setpoint_wr <= 1'b1;
            setpoint_data <= pending_samples[0].sp;
            sp_q = longint'(signed'(pending_samples[0].sp));
            void'(pending_samples.pop_front());
          end
        end else if (!quiet_mode && $urandom_range(99) < 21) begin
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata <= {pending_samples[0].stamp, pending_samples[0].value};
          s_tlast <= pending_samples[0].last;
        end
      end
    end
  end

  // Result monitor with receiver stalls.
  always @(posedge clk) begin
    metrics_t got, exp_m;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tuser[0], m_tdata[63:32], m_tdata[94:64],
               m_tdata[125:95], m_tdata[157:126]};
        if (expected_metrics.size() == 0) begin
          $error("unexpected result word");
          errors++;
        end else begin
          exp_m = expected_metrics.pop_front();
          if (got.rise_duration !== exp_m.rise_duration) begin
            $error("rise_duration exp %0d got %0d", exp_m.rise_duration, got.rise_duration);
            errors++;
          end
          if (got.rise_found !== exp_m.rise_found) begin
            $error("rise_found exp %0d got %0d", exp_m.rise_found, got.rise_found);
            errors++;
          end
          if (got.settle_stamp !== exp_m.settle_stamp) begin
            $error("settle_stamp exp %0d got %0d", exp_m.settle_stamp, got.settle_stamp);
            errors++;
          end
          if (got.overshoot_percent !== exp_m.overshoot_percent) begin
            $error("overshoot_percent exp %0d got %0d", exp_m.overshoot_percent,
                   got.overshoot_percent);
            errors++;
          end
          if (got.final_error !== exp_m.final_error) begin
            $error("final_error exp %0d got %0d", exp_m.final_error, got.final_error);
            errors++;
          end
          if (got.peak_level !== exp_m.peak_level) begin
            $error("peak_level exp %0h got %0h", exp_m.peak_level, got.peak_level);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet_mode || ($urandom_range(99) >= 21);
      end
    end
  end

  // Long receiver hold-off, counted down here.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_item(sample_t s);
    pending_samples.insert(pending_samples.size(), s);
  endtask

  // Queue one run of samples around a setpoint.
  task automatic add_run(longint sp, int len, int mode);
    logic [31:0] stamp;
    longint start_v, v;
    stamp = $urandom;
    start_v = (mode == 0) ? longint'(signed'($urandom))
                          : sp - (sp / 2) + longint'($urandom_range(200)) - 100;
    for (int i = 0; i < len; i++) begin
      if (mode == 0 || i == 0) begin
        v = (mode == 0) ? longint'(signed'($urandom)) : start_v;
      end else begin
        v = start_v + ((sp - start_v) * i * 12) / (10 * len)
            + longint'($urandom_range(64)) - 32;
        if ($urandom_range(9) == 0) v = longint'(signed'($urandom));
      end
      if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
      if (v < -64'sh80000000) v = -64'sh80000000;
      if ($urandom_range(19) == 0) stamp = stamp - $urandom_range(50);
      else stamp = stamp + $urandom_range(100);
      queue_item(sample_t'{value: v[31:0], stamp: stamp, last: (i == len - 1),
                           wr_sp: 1'b0, sp: '0});
    end
  endtask

  task automatic add_setpoint(logic [31:0] sp);
    queue_item(sample_t'{value: '0, stamp: '0, last: 1'b0, wr_sp: 1'b1, sp: sp});
  endtask

  task automatic add_sample(logic [31:0] v, logic [31:0] t, logic last);
    queue_item(sample_t'{value: v, stamp: t, last: last, wr_sp: 1'b0, sp: '0});
  endtask

  function automatic logic [31:0] pick_setpoint();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      3: return $urandom;
      default: return $urandom_range(32'h00400000) - 32'h00200000;
    endcase
  endfunction

  // Latest setpoint queued, so that stepped runs aim near the live target.
  function automatic logic [31:0] sp_pick_last();
    for (int i = pending_samples.size() - 1; i >= 0; i--) begin
      if (pending_samples[i].wr_sp) return pending_samples[i].sp;
    end
    return sp_q[31:0];
  endfunction

  initial begin
    sp_q = 0;
    started = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero setpoint, extremes, single-sample runs, a falling step.
    add_sample(32'h0, 32'h0, 1'b1);
    add_sample(32'h80000000, 32'hFFFFFFFF, 1'b1);
    add_sample(32'h00000000, 32'd10, 1'b0);
    add_sample(32'h00010000, 32'd20, 1'b0);
    add_sample(32'h7FFFFFFF, 32'd5, 1'b1);
    add_setpoint(32'h00640000);
    add_sample(32'h0, 32'd0, 1'b0);
    add_sample(32'h000A0000, 32'd10, 1'b0);
    add_sample(32'h005A0000, 32'd20, 1'b0);
    add_sample(32'h00700000, 32'd30, 1'b0);
    add_sample(32'h00640000, 32'd40, 1'b1);
    add_setpoint(32'h80000000);
    add_sample(32'h7FFFFFFF, 32'd0, 1'b0);
    add_sample(32'h80000000, 32'd3, 1'b1);
    add_setpoint(32'h7FFFFFFF);
    add_sample(32'h80000000, 32'hFFFFFFF0, 1'b0);
    add_sample(32'h7FFFFFFF, 32'h00000005, 1'b1);
    add_setpoint(32'hFF9C0000);
    add_sample(32'h0, 32'd1, 1'b0);
    add_sample(32'hFF900000, 32'd9, 1'b1);

    // Random runs: mostly step-shaped, some pure noise.
    for (int r = 0; r < 130; r++) begin
      if (r % 8 == 0) add_setpoint(pick_setpoint());
      add_run(longint'(signed'(sp_pick_last())), $urandom_range(12, 1),
              ($urandom_range(4) == 0) ? 0 : 1);
      if (r == 40) begin
        wait (pending_samples.size() == 0);
      end
    end
    add_setpoint(32'h00000000);
    repeat (8) add_run(0, $urandom_range(6, 1), 0);

    // Long receiver hold-off while samples keep coming.
    hold_cycles = 3000;
    wait (pending_samples.size() < 200);
    quiet_mode = 1'b1;
    wait (pending_samples.size() < 100);
    quiet_mode = 1'b0;
    // Sender pause until the block drains.
    pause_req = 1'b1;
    wait (expected_metrics.size() == 0 && !started);
    repeat (20) @(posedge clk);
    pause_req = 1'b0;

    wait (pending_samples.size() == 0 && !s_tvalid);
    wait (expected_metrics.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
